### hw/rtl/slps_pkg.sv
package slps_pkg;

    // Build-time options
    localparam int MODE_COUNT = 18;
    localparam logic INVERT_LEVELS = 1'b0;

    typedef logic [4:0]  mode_t;
    typedef logic [2:0]  step_t;
    typedef logic [1:0]  rep_t;
    typedef logic [15:0] dur_t;
    typedef logic [2:0]  rgb_t;   // red, green, blue
    typedef logic [9:0]  color_cfg_t;

    localparam int   CFG_IDX_W = 3;
    localparam int   CFG_DATA_W = 16;
    localparam dur_t WIN_MAX = 16'hFFFF;
    localparam rep_t REP_LAST = 2'd2;

    // Mode codes
    localparam mode_t MODE_OFF       = 5'd0;
    localparam mode_t MODE_BUSY      = 5'd1;
    localparam mode_t MODE_NORM_S_A  = 5'd2;
    localparam mode_t MODE_NORM_S_B  = 5'd3;
    localparam mode_t MODE_NORM_P_A  = 5'd4;
    localparam mode_t MODE_INT_S     = 5'd5;
    localparam mode_t MODE_INT_L3    = 5'd6;
    localparam mode_t MODE_ERR_L3    = 5'd7;
    localparam mode_t MODE_ERR_S3X3  = 5'd8;
    localparam mode_t MODE_ERR_L2X3  = 5'd9;
    localparam mode_t MODE_ERR_SLS   = 5'd10;
    localparam mode_t MODE_INT_P     = 5'd11;
    localparam mode_t MODE_INT_S2    = 5'd12;
    localparam mode_t MODE_INT_L2    = 5'd13;
    localparam mode_t MODE_NORM_P_B  = 5'd14;
    localparam mode_t MODE_DEPLOY    = 5'd15;
    localparam mode_t MODE_MEAS_S    = 5'd16;
    localparam mode_t MODE_MEAS_L2   = 5'd17;
    localparam mode_t MODE_LAST      = MODE_MEAS_L2;

    typedef enum logic [2:0] {
        CFG_COLOR   = 3'd0,
        CFG_VARIANT = 3'd1,
        CFG_SHORT   = 3'd2,
        CFG_LONG    = 3'd3,
        CFG_GAP     = 3'd4,
        CFG_PERM    = 3'd5,
        CFG_PAUSE   = 3'd6,
        CFG_WINDOW  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_OFF  = 2'd0,
        CLS_NORM = 2'd1,
        CLS_INT  = 2'd2,
        CLS_ERR  = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        DUR_S = 3'd0,
        DUR_L = 3'd1,
        DUR_G = 3'd2,
        DUR_P = 3'd3,
        DUR_Z = 3'd4
    } dur_kind_t;

    typedef struct packed {
        cls_t      cls;
        dur_kind_t dur;
    } seg_t;

    localparam rgb_t RGB_OFF    = 3'b000;
    localparam rgb_t RGB_RED    = 3'b100;
    localparam rgb_t RGB_GREEN  = 3'b010;
    localparam rgb_t RGB_YELLOW = 3'b110;

    typedef struct packed {
        rgb_t norm_rgb;
        rgb_t int_rgb;
        rgb_t err_rgb;
        logic rgb_variant;
        dur_t short_ms;
        dur_t long_ms;
        dur_t letter_gap_ms;
        dur_t permanent_ms;
        dur_t pause_ms;
        dur_t window_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        norm_rgb:      RGB_GREEN,
        int_rgb:       RGB_YELLOW,
        err_rgb:       RGB_RED,
        rgb_variant:   1'b0,
        short_ms:      16'd200,
        long_ms:       16'd600,
        letter_gap_ms: 16'd200,
        permanent_ms:  16'd2000,
        pause_ms:      16'd800,
        window_ms:     16'd60000
    };

    typedef struct packed {
        logic  req_type;
        mode_t mode_request;
        logic  busy_flag;
    } item_t;

    typedef struct packed {
        logic  led_red;
        logic  led_green;
        logic  led_blue;
        logic  status_done;
        logic  sensor_start_done;
        logic  measure_led_off;
        mode_t active_mode;
    } res_t;

    function automatic logic mode_valid(mode_t m);
        return (m != MODE_OFF) && (m <= MODE_LAST) && ({1'b0, m} < 6'(MODE_COUNT));
    endfunction

    function automatic logic can_preempt(mode_t m);
        return (m == MODE_BUSY) || (m == MODE_NORM_S_A) || (m == MODE_NORM_S_B)
            || (m == MODE_NORM_P_A) || (m == MODE_NORM_P_B) || (m == MODE_DEPLOY)
            || (m == MODE_MEAS_S) || (m == MODE_MEAS_L2);
    endfunction

    function automatic logic signals_status(mode_t m);
        return (m == MODE_BUSY) || ((m >= MODE_ERR_S3X3) && (m <= MODE_NORM_P_B));
    endfunction

    function automatic step_t seg_count(mode_t m);
        step_t n;
        unique case (m)
            MODE_BUSY, MODE_ERR_L2X3, MODE_INT_S2, MODE_INT_L2, MODE_MEAS_L2: n = 3'd4;
            MODE_INT_L3, MODE_ERR_L3, MODE_ERR_S3X3, MODE_ERR_SLS:           n = 3'd6;
            MODE_NORM_S_A, MODE_NORM_S_B, MODE_NORM_P_A, MODE_INT_S,
            MODE_INT_P, MODE_NORM_P_B, MODE_DEPLOY, MODE_MEAS_S:             n = 3'd2;
            default:                                                         n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic cls_t on_class(mode_t m);
        cls_t c;
        unique case (m)
            MODE_BUSY, MODE_INT_S, MODE_INT_L3, MODE_INT_P,
            MODE_INT_S2, MODE_INT_L2:                                c = CLS_INT;
            MODE_ERR_L3, MODE_ERR_S3X3, MODE_ERR_L2X3, MODE_ERR_SLS: c = CLS_ERR;
            default:                                                 c = CLS_NORM;
        endcase
        return c;
    endfunction

    function automatic dur_kind_t on_dur(mode_t m, step_t s);
        dur_kind_t d;
        unique case (m)
            MODE_BUSY:                    d = (s == 3'd0) ? DUR_L : DUR_S;
            MODE_ERR_SLS:                 d = (s == 3'd2) ? DUR_L : DUR_S;
            MODE_INT_L3, MODE_ERR_L3, MODE_ERR_L2X3,
            MODE_INT_L2, MODE_MEAS_L2:    d = DUR_L;
            MODE_NORM_P_A, MODE_INT_P,
            MODE_NORM_P_B:                d = DUR_P;
            default:                      d = DUR_S;
        endcase
        return d;
    endfunction

    // Odd steps are dark; the closing dark step is a pause except in the
    // deployment and measurement modes (MODE_DEPLOY and up), which close on a gap.
    function automatic seg_t seg_of(mode_t m, step_t s);
        seg_t seg;
        if (s[0])
        begin
            seg.cls = CLS_OFF;
            if ((s == seg_count(m) - 3'd1) && (m < MODE_DEPLOY))
                seg.dur = DUR_Z;
            else
                seg.dur = DUR_G;
        end
        else
        begin
            seg.cls = on_class(m);
            seg.dur = on_dur(m, s);
        end
        return seg;
    endfunction

    // Color code digit to RGB; unused codes take the class fallback
    function automatic rgb_t code_rgb(logic [3:0] code, rgb_t fallback);
        rgb_t c;
        unique case (code)
            4'd1:    c = 3'b100;
            4'd2:    c = 3'b010;
            4'd3:    c = 3'b110;
            4'd4:    c = 3'b001;
            4'd5:    c = 3'b101;
            4'd6:    c = 3'b011;
            4'd7:    c = 3'b111;
            default: c = fallback;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/slps_if.sv
interface slps_in_if;
    import slps_pkg::*;

    logic  valid;
    logic  ready;
    logic  req_type;
    mode_t mode_request;
    logic  busy_flag;

    modport source (output valid, output req_type, output mode_request,
                    output busy_flag, input ready);
    modport sink   (input valid, input req_type, input mode_request,
                    input busy_flag, output ready);
endinterface

interface slps_out_if;
    import slps_pkg::*;

    logic  valid;
    logic  ready;
    logic  led_red;
    logic  led_green;
    logic  led_blue;
    logic  status_done;
    logic  sensor_start_done;
    logic  measure_led_off;
    mode_t active_mode;

    modport source (output valid, output led_red, output led_green, output led_blue,
                    output status_done, output sensor_start_done,
                    output measure_led_off, output active_mode, input ready);
    modport sink   (input valid, input led_red, input led_green, input led_blue,
                    input status_done, input sensor_start_done,
                    input measure_led_off, input active_mode, output ready);
endinterface

### hw/rtl/slps_cfg_regs.sv
module slps_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [slps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output slps_pkg::cfg_t                        cfg
);
    import slps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    color_cfg_t  color_val;
    logic [3:0]  hund_cnt;
    logic [3:0]  tens_cnt;
    logic [9:0]  below_hund;
    logic [3:0]  hund_dig;
    logic [3:0]  tens_dig;
    logic [3:0]  unit_dig;
    dur_t        dur_val;

    // Split the color word into decimal digits with parallel threshold compares
    always_comb
    begin
        color_val = cfg_wdata[9:0];
        hund_cnt = '0;
        for (int k = 1; k <= 10; k++)
        begin
            if (color_val >= 10'(100 * k))
                hund_cnt = hund_cnt + 4'd1;
        end
        hund_dig = (hund_cnt == 4'd10) ? 4'd0 : hund_cnt;
        below_hund = color_val - (10'(hund_cnt) * 10'd100);
        tens_cnt = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (below_hund >= 10'(10 * k))
                tens_cnt = tens_cnt + 4'd1;
        end
        tens_dig = tens_cnt;
        unit_dig = 4'(below_hund - (10'(tens_cnt) * 10'd10));
    end

    // Zero length acts as one tick
    assign dur_val = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COLOR:
                begin
                    cfg_next.norm_rgb = code_rgb(hund_dig, RGB_GREEN);
                    cfg_next.int_rgb  = code_rgb(tens_dig, RGB_YELLOW);
                    cfg_next.err_rgb  = code_rgb(unit_dig, RGB_RED);
                end
                CFG_VARIANT: cfg_next.rgb_variant   = cfg_wdata[0];
                CFG_SHORT:   cfg_next.short_ms      = dur_val;
                CFG_LONG:    cfg_next.long_ms       = dur_val;
                CFG_GAP:     cfg_next.letter_gap_ms = dur_val;
                CFG_PERM:    cfg_next.permanent_ms  = dur_val;
                CFG_PAUSE:   cfg_next.pause_ms      = dur_val;
                CFG_WINDOW:  cfg_next.window_ms     = dur_val;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/slps_seq_core.sv
module slps_seq_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  slps_pkg::item_t item,
    input  slps_pkg::cfg_t  cfg,
    output slps_pkg::res_t  res
);
    import slps_pkg::*;

    mode_t mode_reg,  mode_next;
    step_t step_reg,  step_next;
    rep_t  rep_reg,   rep_next;
    dur_t  rem_reg,   rem_next;
    dur_t  win_reg,   win_next;
    mode_t pend_reg,  pend_next;
    logic  pendv_reg, pendv_next;
    rgb_t  led_reg,   led_next;
    logic  sdone_reg, sdone_next;
    logic  moff_reg,  moff_next;
    logic  pulse;

    step_t step_inc;
    dur_t  win_inc;
    seg_t  seg_step;
    seg_t  seg_first;
    seg_t  seg_start;
    logic  start_en;
    mode_t start_m;
    logic  fin;

    function automatic rgb_t class_rgb(cls_t c, cfg_t k);
        rgb_t v;
        unique case (c)
            CLS_NORM: v = k.norm_rgb;
            CLS_INT:  v = k.int_rgb;
            CLS_ERR:  v = k.err_rgb;
            default:  v = RGB_OFF;
        endcase
        return v;
    endfunction

    function automatic dur_t dur_of(dur_kind_t d, cfg_t k);
        dur_t v;
        unique case (d)
            DUR_S:   v = k.short_ms;
            DUR_L:   v = k.long_ms;
            DUR_G:   v = k.letter_gap_ms;
            DUR_P:   v = k.permanent_ms;
            default: v = k.pause_ms;
        endcase
        return v;
    endfunction

    assign step_inc  = step_reg + 3'd1;
    assign win_inc   = (win_reg != WIN_MAX) ? win_reg + 16'd1 : win_reg;
    assign seg_step  = seg_of(mode_reg, step_inc);
    assign seg_first = seg_of(mode_reg, 3'd0);
    assign seg_start = seg_of(start_m, 3'd0);

    always_comb
    begin
        mode_next  = mode_reg;
        step_next  = step_reg;
        rep_next   = rep_reg;
        rem_next   = rem_reg;
        win_next   = win_reg;
        pend_next  = pend_reg;
        pendv_next = pendv_reg;
        led_next   = led_reg;
        sdone_next = sdone_reg;
        moff_next  = moff_reg;
        pulse      = 1'b0;
        start_en   = 1'b0;
        start_m    = item.mode_request;
        fin        = 1'b0;

        if (item.req_type)
        begin
            if (mode_reg == MODE_OFF)
                start_en = 1'b1;
            else if (can_preempt(mode_reg))
            begin
                // drop the playing mode; no completion pulse
                if (mode_reg == MODE_DEPLOY)
                    sdone_next = 1'b1;
                led_next  = RGB_OFF;
                mode_next = MODE_OFF;
                start_en  = 1'b1;
            end
            else
            begin
                pend_next  = item.mode_request;
                pendv_next = 1'b1;
            end
        end
        else if (mode_reg != MODE_OFF)
        begin
            if (mode_reg == MODE_DEPLOY)
                win_next = win_inc;
            if (rem_reg > 16'd1)
                rem_next = rem_reg - 16'd1;
            else
            begin
                rem_next = '0;
                if (step_inc < seg_count(mode_reg))
                begin
                    step_next = step_inc;
                    led_next  = class_rgb(seg_step.cls, cfg);
                    rem_next  = dur_of(seg_step.dur, cfg);
                end
                else
                begin
                    step_next = '0;
                    fin = 1'b1;
                    if (mode_reg == MODE_BUSY)
                        fin = !item.busy_flag;
                    else if ((mode_reg == MODE_ERR_S3X3) || (mode_reg == MODE_ERR_L2X3))
                    begin
                        if (rep_reg != REP_LAST)
                        begin
                            rep_next = rep_reg + 2'd1;
                            fin = 1'b0;
                        end
                        else
                            rep_next = '0;
                    end
                    else if (mode_reg == MODE_DEPLOY)
                        fin = !(win_inc < cfg.window_ms);

                    if (!fin)
                    begin
                        led_next = class_rgb(seg_first.cls, cfg);
                        rem_next = dur_of(seg_first.dur, cfg);
                    end
                    else
                    begin
                        led_next  = RGB_OFF;
                        pulse     = signals_status(mode_reg);
                        if (mode_reg == MODE_DEPLOY)
                            sdone_next = 1'b1;
                        if ((mode_reg == MODE_MEAS_S) || (mode_reg == MODE_MEAS_L2))
                            moff_next = 1'b1;
                        mode_next = MODE_OFF;
                        if (pendv_reg)
                        begin
                            pendv_next = 1'b0;
                            start_en   = 1'b1;
                            start_m    = pend_reg;
                        end
                    end
                end
            end
        end

        if (start_en)
        begin
            if (!mode_valid(start_m))
            begin
                mode_next = MODE_OFF;
                led_next  = RGB_OFF;
            end
            else
            begin
                mode_next = start_m;
                step_next = '0;
                rep_next  = '0;
                win_next  = '0;
                if (start_m == MODE_DEPLOY)
                    sdone_next = 1'b0;
                if ((start_m == MODE_MEAS_S) || (start_m == MODE_MEAS_L2))
                    moff_next = 1'b0;
                led_next = class_rgb(seg_start.cls, cfg);
                rem_next = dur_of(seg_start.dur, cfg);
            end
        end
    end

    always_comb
    begin
        res.led_red   = (cfg.rgb_variant ? led_next[2] : (|led_next)) ^ INVERT_LEVELS;
        res.led_green = (cfg.rgb_variant & led_next[1]) ^ INVERT_LEVELS;
        res.led_blue  = (cfg.rgb_variant & led_next[0]) ^ INVERT_LEVELS;
        res.status_done       = pulse;
        res.sensor_start_done = sdone_next;
        res.measure_led_off   = moff_next;
        res.active_mode       = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            step_reg  <= '0;
            rep_reg   <= '0;
            rem_reg   <= '0;
            win_reg   <= '0;
            pend_reg  <= MODE_OFF;
            pendv_reg <= 1'b0;
            led_reg   <= RGB_OFF;
            sdone_reg <= 1'b0;
            moff_reg  <= 1'b1;
        end
        else if (adv)
        begin
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            rep_reg   <= rep_next;
            rem_reg   <= rem_next;
            win_reg   <= win_next;
            pend_reg  <= pend_next;
            pendv_reg <= pendv_next;
            led_reg   <= led_next;
            sdone_reg <= sdone_next;
            moff_reg  <= moff_next;
        end
    end

    // A queued request only exists behind a mode that cannot be dropped
    a_pend_owner: assert property (@(posedge clk) disable iff (!rst_n)
        pendv_reg |-> ((mode_reg != MODE_OFF) && !can_preempt(mode_reg)))
        else $error("pending request without a non-preemptible mode");

    // A playing mode always has at least one tick left in its segment
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_OFF) |-> (rem_reg != '0))
        else $error("playing mode with empty segment timer");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_OFF) |-> (step_reg < seg_count(mode_reg)))
        else $error("segment index beyond pattern length");

    a_rep_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (rep_reg != '0) |-> ((mode_reg == MODE_ERR_S3X3) || (mode_reg == MODE_ERR_L2X3)))
        else $error("repeat count set outside the repeating error modes");

    a_led_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OFF) |-> (led_reg == RGB_OFF))
        else $error("LED lit while idle");

endmodule

### hw/rtl/status_led_pattern_sequencer.sv
// Status LED pattern sequencer.
//
// item channel: one beat is either a 1 ms tick (req_type 0, busy_flag sampled
// at the end of each round of the busy mode) or a mode request (req_type 1,
// mode_request 0 for off, 1..17 for a pattern).
// result channel: exactly one beat per item beat, carrying the RGB pin levels,
// the completion pulse, the sensor_start_done and measure_led_off flags and the mode now playing.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (color word, variant, five segment lengths, blink window). Write only while
// no item is in flight.
//
// From item accept to result valid, an item passes the item register, then the
// sequencer next-state logic into the result register. Throughput is one item
// per cycle while the result receiver is ready; the segment lookup and timer
// update finish in one pass. When the result receiver stalls, the result register
// holds and the item register fills; item.ready drops only when both are occupied.
// Reset clears the sequencer to idle with LEDs off, sensor_start_done low,
// measure_led_off high, and loads the default segment lengths.
module status_led_pattern_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    slps_in_if.sink                           item,
    slps_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [slps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import slps_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg;
    logic  item_valid_next;
    res_t  res_reg;
    res_t  res;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  in_fire;
    logic  adv;

    slps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the held item whenever the result register is free or draining
    assign adv = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || adv;
    assign in_fire = item.valid && item.ready;

    assign item_valid_next = in_fire || (item_valid_reg && !adv);
    assign out_valid_next  = adv || (out_valid_reg && !result.ready);

    slps_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: item captured on accept, result on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.req_type     <= item.req_type;
            item_reg.mode_request <= item.mode_request;
            item_reg.busy_flag    <= item.busy_flag;
        end
        if (adv)
            res_reg <= res;
    end

    assign result.valid             = out_valid_reg;
    assign result.led_red           = res_reg.led_red;
    assign result.led_green         = res_reg.led_green;
    assign result.led_blue          = res_reg.led_blue;
    assign result.status_done       = res_reg.status_done;
    assign result.sensor_start_done = res_reg.sensor_start_done;
    assign result.measure_led_off   = res_reg.measure_led_off;
    assign result.active_mode       = res_reg.active_mode;

    // The core only steps with a held item, and never into a full result slot
    a_adv_src: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> (item_valid_reg && (!out_valid_reg || result.ready)))
        else $error("sequencer stepped without a free result slot");

    // Every advanced item shows up as a result beat on the next cycle
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced item produced no result beat");

    // A stalled result keeps the held item in the item register
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !adv) |=> item_valid_reg)
        else $error("held item lost while stalled");

endmodule
